// ===== sv/wqs_pkg.sv =====
// Package with widths, fixed-point constants, breakpoint tables and segment lookup.
`timescale 1ns / 1ps
`default_nettype none
package wqs_pkg;

	localparam int PH_W  = 11;
	localparam int OX_W  = 12;
	localparam int TMP_W = 12;
	localparam int NH_W  = 16;
	localparam int TU_W  = 16;
	localparam int IDX_W = 14;

	localparam int IN_W  = 72;
	localparam int OUT_W = 56;

	localparam int DIV_NW = 56;
	localparam int DIV_DW = 30;
	localparam int DIV_QW = 30;

	localparam int X_W     = 30;
	localparam int D_W     = 26;
	localparam int SLOPE_W = 13;
	localparam int PROD_W  = D_W + SLOPE_W;

	localparam int POLY_W = 57;
	localparam logic [POLY_W-1:0] POLY_A = 57'd14652000000000000;
	localparam logic [41:0] POLY_B = 42'd4102200000000;
	localparam logic [29:0] POLY_C = 30'd799100000;
	localparam logic [16:0] POLY_D = 17'd77774;
	localparam logic [39:0] PCT_SCALE = 40'd1000000000000;

	// Division by 10^9 is a shift by 9 and a division by 5^9 through its reciprocal.
	localparam logic [24:0] SAT_RECIP = 25'd18014398;
	localparam logic [22:0] SAT_K  = 23'd1953125;
	localparam logic [22:0] SAT_K2 = 23'd3906250;
	localparam logic [22:0] SAT_K3 = 23'd5859375;

	localparam int SIDE_LEN = 39;
	localparam int TAIL_LEN = 31;
	localparam int VAL_LEN  = 71;
	localparam int NCH      = 4;

	typedef logic [X_W-1:0] bp_arr_t [8];
	typedef int q_arr_t [8];

	localparam bp_arr_t DO_BP = '{30'd20000000, 30'd50000000, 30'd75000000, 30'd88000000,
		30'd112000000, 30'd125000000, 30'd150000000, 30'd200000000};
	localparam q_arr_t DO_Q = '{25, 50, 75, 100, 100, 75, 50, 25};
	localparam bp_arr_t PH_BP = '{30'd550, 30'd600, 30'd850, 30'd900,
		30'd0, 30'd0, 30'd0, 30'd0};
	localparam q_arr_t PH_Q = '{50, 100, 100, 50, 0, 0, 0, 0};
	localparam bp_arr_t NH_BP = '{30'd100, 30'd200, 30'd500, 30'd1000, 30'd5000,
		30'd0, 30'd0, 30'd0};
	localparam bp_arr_t TU_BP = '{30'd50, 30'd200, 30'd300, 30'd700, 30'd1000,
		30'd0, 30'd0, 30'd0};
	localparam q_arr_t CL_Q = '{100, 75, 50, 25, 1, 0, 0, 0};

	typedef struct packed {
		logic [PH_W-1:0]  ph;
		logic [OX_W-1:0]  oxy;
		logic [TMP_W-1:0] tmp;
		logic [NH_W-1:0]  nh;
		logic [TU_W-1:0]  tu;
	} side_t;

	typedef struct packed {
		logic               clamp;
		logic [IDX_W-1:0]   clamp_val;
		logic [IDX_W-1:0]   base;
		logic               neg;
	} tail_t;

	typedef struct packed {
		tail_t              tl;
		logic [SLOPE_W-1:0] slope;
		logic [D_W-1:0]     d;
		logic [D_W-1:0]     w;
	} seg_t;

	// Finds the segment holding x; band tables give index 1 at or outside their end points.
	function automatic seg_t seg_lookup(input logic [X_W-1:0] x, input bp_arr_t bp,
		input q_arr_t q, input int n, input logic band);
		seg_t s;
		int dq;
		s = '0;
		s.w = D_W'(1);
		if (x <= bp[0] || x >= bp[n-1]) begin
			s.tl.clamp = 1'b1;
			if (band) begin
				s.tl.clamp_val = IDX_W'(100);
			end else if (x <= bp[0]) begin
				s.tl.clamp_val = IDX_W'(q[0] * 100);
			end else begin
				s.tl.clamp_val = IDX_W'(q[n-1] * 100);
			end
		end else begin
			for (int i = 6; i >= 0; i--) begin
				if (i < n - 1 && x <= bp[i+1]) begin
					dq = q[i+1] - q[i];
					s.w = D_W'(bp[i+1] - bp[i]);
					s.d = D_W'(x - bp[i]);
					s.tl.base = IDX_W'(q[i] * 100);
					s.tl.neg = (dq < 0);
					s.slope = SLOPE_W'(((dq < 0) ? -dq : dq) * 100);
				end
			end
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== sv/wqs_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
module wqs_div (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [wqs_pkg::DIV_NW-1:0]    num,
	input  wire logic [wqs_pkg::DIV_DW-1:0]    den,
	output logic      [wqs_pkg::DIV_QW-1:0]    quo,
	output logic                               rem_nz
);
	import wqs_pkg::*;

	logic [DIV_DW-1:0] r_s [DIV_QW];
	logic [DIV_QW-1:0] z_s [DIV_QW];
	logic [DIV_DW-1:0] d_s [DIV_QW];
	logic [DIV_DW-1:0] r_n [DIV_QW];
	logic [DIV_QW-1:0] z_n [DIV_QW];

	always_comb begin
		logic [DIV_DW-1:0] r_in;
		logic [DIV_QW-1:0] z_in;
		logic [DIV_DW-1:0] d_in;
		logic [DIV_DW:0]   t;
		logic              ge;
		for (int k = 0; k < DIV_QW; k++) begin
			if (k == 0) begin
				r_in = DIV_DW'(num[DIV_NW-1:DIV_QW]);
				z_in = num[DIV_QW-1:0];
				d_in = den;
			end else begin
				r_in = r_s[k-1];
				z_in = z_s[k-1];
				d_in = d_s[k-1];
			end
			t = {r_in, z_in[DIV_QW-1]};
			ge = (t >= {1'b0, d_in});
			r_n[k] = ge ? DIV_DW'(t - {1'b0, d_in}) : DIV_DW'(t);
			z_n[k] = {z_in[DIV_QW-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= den;
			for (int k = 0; k < DIV_QW; k++) begin
				r_s[k] <= r_n[k];
				z_s[k] <= z_n[k];
			end
			for (int k = 1; k < DIV_QW; k++) d_s[k] <= d_s[k-1];
		end
	end

	assign quo = z_s[DIV_QW-1];
	assign rem_nz = (r_s[DIV_QW-1] != '0);
endmodule
`default_nettype wire

// ===== sv/water_quality_subindex.sv =====
// Top level: four water-quality sub-indices from one set of readings.
//
//  channel  | dir | width | beat contents
//  s_axis   | in  | 72    | one set of readings
//  m_axis   | out | 56    | four sub-indices in hundredths
//
// One beat enters per cycle while the skid register is empty; its result passes five
// stages of saturation polynomial, three stages dividing it by 10^9, two 30-stage
// dividers (percent saturation, interpolation), the lookup and multiply stages between
// them and the output stage.
// Reset clears the valid bits only; data registers keep what they hold.
// A two-entry output stage lets a new beat in while a result waits; the whole
// pipeline holds while the skid register is full.
`timescale 1ns / 1ps
`default_nettype none
module water_quality_subindex (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// ph_reading, oxygen_reading, water_temperature, ammonium_reading, turbidity_reading
	input  wire logic [wqs_pkg::IN_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// oxygen_index, ph_index, ammonium_index, turbidity_index
	output logic      [wqs_pkg::OUT_W-1:0] m_tdata
);
	import wqs_pkg::*;

	logic en;
	logic v_s [VAL_LEN];
	side_t side_s [SIDE_LEN];
	side_t side_in;

	logic [23:0]       t2_s2;
	logic [53:0]       tb_s2;
	logic [TMP_W-1:0]  t_s2;
	logic [35:0]       t3_s3;
	logic [53:0]       tc_s3;
	logic [POLY_W-1:0] acc1_s3;
	logic [52:0]       td_s4;
	logic [POLY_W-1:0] acc2_s4;
	logic [POLY_W-1:0] n_s5;

	logic [24:0]       qe_s6;
	logic [44:0]       m_s6;
	logic [24:0]       qe_s7;
	logic [22:0]       r_s7;
	logic [23:0]       sat_s8;

	logic [DIV_NW-1:0] num2_s9;
	logic [DIV_DW-1:0] den2_s9;
	logic [DIV_QW-1:0] pct_quo;
	logic              pct_rnz;

	seg_t seg_s40 [NCH];
	logic [PROD_W-1:0] prod_s41 [NCH];
	logic [D_W-1:0]    w_s41 [NCH];
	tail_t tail_s [TAIL_LEN][NCH];
	logic [DIV_QW-1:0] iq [NCH];
	logic              irnz [NCH];
	logic [IDX_W-1:0]  idx [NCH];
	logic [OUT_W-1:0]  res;

	logic [OUT_W-1:0] out_q;
	logic             out_v_q;
	logic [OUT_W-1:0] skid_q;
	logic             skid_v_q;
	logic             take;

	assign en = !skid_v_q;
	assign s_tready = en;

	assign side_in.ph  = s_tdata[10:0];
	assign side_in.oxy = s_tdata[22:11];
	assign side_in.tmp = s_tdata[34:23];
	assign side_in.nh  = s_tdata[50:35];
	assign side_in.tu  = s_tdata[66:51];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VAL_LEN; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= s_tvalid;
			for (int k = 1; k < VAL_LEN; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < SIDE_LEN; k++) side_s[k] <= side_s[k-1];

			t_s2 <= side_s[0].tmp;
			t2_s2 <= 24'(side_s[0].tmp) * 24'(side_s[0].tmp);
			tb_s2 <= 54'(POLY_B) * 54'(side_s[0].tmp);

			t3_s3 <= 36'(t2_s2) * 36'(t_s2);
			tc_s3 <= 54'(POLY_C) * 54'(t2_s2);
			acc1_s3 <= POLY_A - POLY_W'(tb_s2);

			td_s4 <= 53'(POLY_D) * 53'(t3_s3);
			acc2_s4 <= acc1_s3 + POLY_W'(tc_s3);

			n_s5 <= acc2_s4 - POLY_W'(td_s4);

			// The estimate from the upper bits is at most three below the true quotient.
			qe_s6 <= 25'((49'(n_s5[53:30]) * 49'(SAT_RECIP)) >> 24);
			m_s6 <= n_s5[53:9];

			qe_s7 <= qe_s6;
			r_s7 <= 23'(m_s6 - 45'(46'(qe_s6) * 46'(SAT_K)));

			sat_s8 <= 24'(qe_s7) + 24'(r_s7 >= SAT_K) + 24'(r_s7 >= SAT_K2)
				+ 24'(r_s7 >= SAT_K3);

			num2_s9 <= DIV_NW'(52'(PCT_SCALE) * 52'(side_s[7].oxy));
			den2_s9 <= (sat_s8 == '0) ? DIV_DW'(1) : DIV_DW'(sat_s8);

			seg_s40[0] <= seg_lookup(pct_quo, DO_BP, DO_Q, 8, 1'b1);
			seg_s40[1] <= seg_lookup(X_W'(side_s[38].ph), PH_BP, PH_Q, 4, 1'b1);
			seg_s40[2] <= seg_lookup(X_W'(side_s[38].nh), NH_BP, CL_Q, 5, 1'b0);
			seg_s40[3] <= seg_lookup(X_W'(side_s[38].tu), TU_BP, CL_Q, 5, 1'b0);

			for (int c = 0; c < NCH; c++) begin
				prod_s41[c] <= PROD_W'(seg_s40[c].slope) * PROD_W'(seg_s40[c].d);
				w_s41[c] <= seg_s40[c].w;
				tail_s[0][c] <= seg_s40[c].tl;
				for (int k = 1; k < TAIL_LEN; k++) tail_s[k][c] <= tail_s[k-1][c];
			end
		end
	end

	wqs_div u_pct_div (
		.clk    (clk),
		.en     (en),
		.num    (num2_s9),
		.den    (den2_s9),
		.quo    (pct_quo),
		.rem_nz (pct_rnz)
	);

	for (genvar c = 0; c < NCH; c++) begin : g_interp
		wqs_div u_int_div (
			.clk    (clk),
			.en     (en),
			.num    (DIV_NW'(prod_s41[c])),
			.den    (DIV_DW'(w_s41[c])),
			.quo    (iq[c]),
			.rem_nz (irnz[c])
		);
	end

	always_comb begin
		tail_t tl;
		for (int c = 0; c < NCH; c++) begin
			tl = tail_s[TAIL_LEN-1][c];
			if (tl.clamp) begin
				idx[c] = tl.clamp_val;
			end else if (tl.neg) begin
				idx[c] = tl.base - IDX_W'(iq[c][SLOPE_W-1:0]) - IDX_W'(irnz[c]);
			end else begin
				idx[c] = tl.base + IDX_W'(iq[c][SLOPE_W-1:0]);
			end
		end
		res = {idx[3], idx[2], idx[1], idx[0]};
	end

	assign take = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) skid_v_q <= 1'b0;
		end else if (v_s[VAL_LEN-1]) begin
			if (!out_v_q || take) out_v_q <= 1'b1;
			else skid_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) out_q <= skid_q;
		end else if (v_s[VAL_LEN-1]) begin
			if (!out_v_q || take) out_q <= res;
			else skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;
endmodule
`default_nettype wire

// ===== tb/water_quality_subindex_tb.sv =====
// Testbench for water_quality_subindex: directed table and random readings vs. a predictor.
`timescale 1ns / 1ps
module water_quality_subindex_tb;
	import wqs_pkg::*;

	typedef struct packed {
		logic [TU_W-1:0]  tu;
		logic [NH_W-1:0]  nh;
		logic [TMP_W-1:0] tmp;
		logic [OX_W-1:0]  oxy;
		logic [PH_W-1:0]  ph;
	} readings_t;

	typedef struct packed {
		logic [IDX_W-1:0] tu;
		logic [IDX_W-1:0] nh;
		logic [IDX_W-1:0] ph;
		logic [IDX_W-1:0] oxy;
	} indices_t;

	typedef struct {
		readings_t r;
		logic      has_exp;
		indices_t  e;
	} row_t;

	localparam int LIMIT = 400000;
	localparam int N_RANDOM = 630;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	indices_t pending_indices[$];
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int cycles = 0;
	logic stim_done = 1'b0;

	water_quality_subindex DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	function automatic longint interp(longint x, longint bp[], longint q[]);
		longint w, num;
		int n;
		n = bp.size();
		if (x <= bp[0]) return q[0] * 100;
		if (x >= bp[n-1]) return q[n-1] * 100;
		for (int i = 0; i < n - 1; i++) begin
			if (x <= bp[i+1]) begin
				w = bp[i+1] - bp[i];
				num = q[i] * 100 * w + (q[i+1] - q[i]) * 100 * (x - bp[i]);
				if (num < 0) num = 0;
				return num / w;
			end
		end
		return q[n-1] * 100;
	endfunction

	function automatic indices_t predict_indices(readings_t r);
		indices_t o;
		longint t, sat15, sat6, pct, x;
		longint dob[] = '{20000000, 50000000, 75000000, 88000000,
			112000000, 125000000, 150000000, 200000000};
		longint doq[] = '{25, 50, 75, 100, 100, 75, 50, 25};
		longint phb[] = '{550, 600, 850, 900};
		longint phq[] = '{50, 100, 100, 50};
		longint nhb[] = '{100, 200, 500, 1000, 5000};
		longint tub[] = '{50, 200, 300, 700, 1000};
		longint clq[] = '{100, 75, 50, 25, 1};
		t = r.tmp;
		sat15 = 64'sd14652000000000000 - 64'sd4102200000000 * t
			+ 64'sd799100000 * t * t - 64'sd77774 * t * t * t;
		sat6 = sat15 / 64'sd1000000000;
		if (sat6 < 1) sat6 = 1;
		pct = longint'(r.oxy) * 64'sd1000000000000 / sat6;
		if (pct <= dob[0] || pct >= dob[7]) o.oxy = 100;
		else o.oxy = IDX_W'(interp(pct, dob, doq));
		x = r.ph;
		if (x <= 550 || x >= 900) o.ph = 100;
		else o.ph = IDX_W'(interp(x, phb, phq));
		o.nh = IDX_W'(interp(r.nh, nhb, clq));
		o.tu = IDX_W'(interp(r.tu, tub, clq));
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at result %0d: %s got %0d expected %0d", beats_out, what, got, want);
		errors++;
	endtask

	function automatic int short_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	task automatic send_reading(readings_t r);
		int gap;
		gap = short_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pending_indices.push_back(predict_indices(r));
		s_tdata <= IN_W'(r);
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		beats_in++;
		@(negedge clk);
	endtask

	function automatic readings_t random_reading();
		readings_t r;
		r.ph  = ($urandom_range(0, 9) == 0) ? PH_W'($urandom) : PH_W'($urandom_range(450, 1000));
		r.oxy = ($urandom_range(0, 9) == 0) ? OX_W'($urandom) : OX_W'($urandom_range(100, 2200));
		r.tmp = ($urandom_range(0, 9) == 0) ? TMP_W'($urandom) : TMP_W'($urandom_range(0, 4000));
		case ($urandom_range(0, 3))
			0: r.nh = NH_W'($urandom);
			default: r.nh = NH_W'($urandom_range(0, 6000));
		endcase
		case ($urandom_range(0, 3))
			0: r.tu = TU_W'($urandom);
			default: r.tu = TU_W'($urandom_range(0, 1200));
		endcase
		return r;
	endfunction

	// Directed rows: typed results only where the clamps make them obvious.
	row_t rows[] = '{
		'{'{16'd0, 16'd0, 12'd0, 12'd0, 11'd0}, 1'b1, '{14'd10000, 14'd10000, 14'd100, 14'd100}},
		'{'{16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 11'h7FF}, 1'b1,
			'{14'd100, 14'd100, 14'd100, 14'd100}},
		'{'{16'd50, 16'd100, 12'd2000, 12'd0, 11'd550}, 1'b1,
			'{14'd10000, 14'd10000, 14'd100, 14'd100}},
		'{'{16'd1000, 16'd5000, 12'd2000, 12'd0, 11'd900}, 1'b1,
			'{14'd100, 14'd100, 14'd100, 14'd100}},
		'{'{16'd200, 16'd200, 12'd2000, 12'd884, 11'd600}, 1'b0, '0},
		'{'{16'd300, 16'd500, 12'd2000, 12'd800, 11'd700}, 1'b0, '0},
		'{'{16'd700, 16'd1000, 12'd1000, 12'd900, 11'd850}, 1'b0, '0},
		'{'{16'd51, 16'd101, 12'd2500, 12'd200, 11'd551}, 1'b0, '0},
		'{'{16'd999, 16'd4999, 12'd0, 12'd1500, 11'd899}, 1'b0, '0},
		'{'{16'd125, 16'd150, 12'd4000, 12'd500, 11'd575}, 1'b0, '0},
		'{'{16'd500, 16'd3000, 12'd3000, 12'd1100, 11'd875}, 1'b0, '0},
		'{'{16'd250, 16'd750, 12'd1500, 12'd1200, 11'd1400}, 1'b0, '0},
		'{'{16'd0, 16'd0, 12'd2000, 12'd4000, 11'd800}, 1'b0, '0},
		'{'{16'd0, 16'd0, 12'd2000, 12'd1800, 11'd800}, 1'b0, '0},
		'{'{16'd0, 16'd0, 12'd2000, 12'd1400, 11'd800}, 1'b0, '0},
		'{'{16'd0, 16'd0, 12'd2000, 12'd400, 11'd800}, 1'b0, '0}
	};

	always @(posedge clk) begin
		indices_t got, want;
		cycles <= cycles + 1;
		if (m_tvalid && m_tready) begin
			got = indices_t'(m_tdata);
			beats_out++;
			if (pending_indices.size() == 0) begin
				$display("unexpected result beat %0d", beats_out);
				errors++;
			end else begin
				want = pending_indices.pop_front();
				if (got.oxy !== want.oxy) report_mismatch("oxygen_index", got.oxy, want.oxy);
				if (got.ph !== want.ph) report_mismatch("ph_index", got.ph, want.ph);
				if (got.nh !== want.nh) report_mismatch("ammonium_index", got.nh, want.nh);
				if (got.tu !== want.tu) report_mismatch("turbidity_index", got.tu, want.tu);
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stim_done) begin
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 99) < 3) begin
			m_tready <= 1'b0;
		end else if (!m_tready) begin
			m_tready <= ($urandom_range(0, 9) < 3);
		end else begin
			m_tready <= ($urandom_range(0, 9) != 0);
		end
	end

	always @(posedge clk) begin
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		readings_t r;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (rows[i]) begin
			if (rows[i].has_exp) begin
				if (predict_indices(rows[i].r) !== rows[i].e) begin
					$display("predictor disagrees with table row %0d", i);
					errors++;
				end
			end
			send_reading(rows[i].r);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			r = random_reading();
			send_reading(r);
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
		wait (pending_indices.size() == 0);
		repeat (150) @(posedge clk);
		$display("Sent %0d reading beats (directed clamps, breakpoints, random sweep);", beats_in);
		$display("received %0d result beats with random stalls on both sides.", beats_out);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
